FILE: rtl/spq_pkg.sv
// Package for the sorted-insert priority queue: sizes, codes and word types.
// Used by spq_cell and sorted_insert_priority_queue_unit; depends on nothing.
package spq_pkg;

  // Store size and key width.
  localparam int CAPACITY   = 16;
  localparam int KEY_BITS   = 16;
  localparam int COUNT_BITS = $clog2(CAPACITY + 1);

  // Fixed field widths of the request and response words.
  localparam int PRIO_BITS = 16;
  localparam int OCC_BITS  = 5;

  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  // Request actions.
  typedef enum logic [1:0] {
    ACT_ENQUEUE = 2'd0,
    ACT_DEQUEUE = 2'd1,
    ACT_CLEAR   = 2'd2,
    ACT_NOP     = 2'd3
  } action_t;

  // Response status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Command broadcast to every cell.
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_POP    = 2'd2
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    key_t      new_key;
  } cell_ctrl_t;

  // Request word.
  typedef struct packed {
    logic [1:0]           action;
    logic [PRIO_BITS-1:0] priority_req;
  } req_word_t;

  // Response word.
  typedef struct packed {
    logic [PRIO_BITS-1:0] removed_priority;
    logic [PRIO_BITS-1:0] front_priority;
    logic [OCC_BITS-1:0]  occupancy;
    logic [1:0]           status;
  } rsp_word_t;

endpackage

FILE: rtl/spq_cell.sv
// One cell of the sorted key chain: holds one key and exchanges keys with both neighbours.
// Depends on spq_pkg.
module spq_cell
  import spq_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       occupied,
  input  key_t       prev_key,
  input  logic       prev_ins,
  input  key_t       next_key,
  output logic       ins,
  output key_t       key,
  output key_t       key_next
);

  // The new key goes in front of this cell if the cell is empty or holds a smaller key.
  assign ins = !occupied || (key < ctrl.new_key);

  // Next key: take the new key at the insertion point, shift back behind it,
  // shift forward on a pop.
  always_comb begin
    key_next = key;
    unique case (ctrl.cmd)
      CELL_HOLD: begin
        key_next = key;
      end
      CELL_INSERT: begin
        if (ins) begin
          key_next = prev_ins ? prev_key : ctrl.new_key;
        end
      end
      CELL_POP: begin
        key_next = next_key;
      end
      default: begin
        key_next = key;
      end
    endcase
  end

  // Key register; contents are only read below the stored count.
  always_ff @(posedge clk) begin
    key <= key_next;
  end

endmodule

FILE: rtl/sorted_insert_priority_queue_unit.sv
// Top level of the sorted-insert priority queue: control, count and the chain of cells.
// Depends on spq_pkg and spq_cell.
//
//   channel   | handshake       | word
//   ----------+-----------------+-----------------------------------------------
//   request   | start / busy    | req: action, priority_req
//   response  | done (strobe)   | rsp: removed_priority, front_priority,
//             |                 |      occupancy, status
//
// One request word is taken every cycle; busy never rises.
// Each response word appears on rsp with done high in the cycle after the
// request is taken, set by the response word and strobe registers.
// Every cell compares and shifts in parallel, so no action needs a serial pass over the chain.
// Synchronous reset empties the store; no clearing pass is needed.
// The receiver cannot stall, so nothing waits on the response side.
module sorted_insert_priority_queue_unit
  import spq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  req_word_t req,
  output logic      done,
  output rsp_word_t rsp
);

  count_t     count;
  count_t     count_next;
  cell_ctrl_t ctrl;
  rsp_word_t  rsp_next;
  status_t    status_next;
  key_t       removed_next;
  logic       accept;

  logic [CAPACITY-1:0] occupied;
  logic [CAPACITY-1:0] ins;
  key_t                cell_key      [CAPACITY];
  key_t                cell_key_next [CAPACITY];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Decode the request into a cell command and the new count.
  always_comb begin
    ctrl.cmd     = CELL_HOLD;
    ctrl.new_key = KEY_BITS'(req.priority_req);
    count_next   = count;
    status_next  = ST_OK;
    removed_next = '0;
    if (accept) begin
      unique case (action_t'(req.action))
        ACT_ENQUEUE: begin
          if (count >= COUNT_BITS'(CAPACITY)) begin
            status_next = ST_FULL;
          end else begin
            ctrl.cmd   = CELL_INSERT;
            count_next = count + 1'b1;
          end
        end
        ACT_DEQUEUE: begin
          if (count == '0) begin
            status_next = ST_EMPTY;
          end else begin
            ctrl.cmd     = CELL_POP;
            removed_next = cell_key[0];
            count_next   = count - 1'b1;
          end
        end
        ACT_CLEAR: begin
          count_next = '0;
        end
        ACT_NOP: begin
          count_next = count;
        end
        default: begin
          count_next = count;
        end
      endcase
    end
  end

  // Chain of cells; the ends see an empty neighbour.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic prev_ins_i;
    key_t prev_key_i;
    key_t next_key_i;

    assign occupied[i] = COUNT_BITS'(i) < count;

    if (i == 0) begin : g_head
      assign prev_ins_i = 1'b0;
      assign prev_key_i = '0;
    end else begin : g_body
      assign prev_ins_i = ins[i-1];
      assign prev_key_i = cell_key[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_key_i = '0;
    end else begin : g_inner
      assign next_key_i = cell_key[i+1];
    end

    spq_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .occupied (occupied[i]),
      .prev_key (prev_key_i),
      .prev_ins (prev_ins_i),
      .next_key (next_key_i),
      .ins      (ins[i]),
      .key      (cell_key[i]),
      .key_next (cell_key_next[i])
    );
  end

  // Assemble the response word from the state after the step.
  always_comb begin
    rsp_next.removed_priority = PRIO_BITS'(removed_next);
    rsp_next.front_priority   = (count_next != '0) ? PRIO_BITS'(cell_key_next[0]) : '0;
    rsp_next.occupancy        = OCC_BITS'(count_next);
    rsp_next.status           = status_next;
  end

  // Count and strobe registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
  end

  // Response word register.
  always_ff @(posedge clk) begin
    rsp <= rsp_next;
  end

endmodule

FILE: bench/sorted_insert_priority_queue_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the sorted-insert priority queue: directed words, then random traffic.
// Depends on spq_pkg and the sorted_insert_priority_queue_unit RTL; needs no files or arguments.
module sorted_insert_priority_queue_unit_tb;
  import spq_pkg::*;

  localparam int RANDOM_WORDS = 500;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int PRINT_CAP    = 30;

  // One row of stimulus; typed rows carry their response, the rest use the queue model.
  typedef struct packed {
    req_word_t req;
    logic      typed;
    rsp_word_t rsp;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  req_word_t req = '0;
  logic      busy;
  logic      done;
  rsp_word_t rsp;

  stim_row_t stim[$];
  rsp_word_t pending_rsp[$];
  rsp_word_t due;

  // Software copy of the sorted store.
  key_t model_keys[CAPACITY];
  int   model_count = 0;

  int error_count = 0;
  int cycle_count = 0;
  int checked_count = 0;
  int full_hits = 0;
  int empty_hits = 0;
  int peak_count = 0;

  sorted_insert_priority_queue_unit i_dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding", cycle_count,
               pending_rsp.size());
      $display("sorted_insert_priority_queue_unit_tb: done, errors");
      $finish;
    end
  end

  // Prints one line per mismatch, up to a cap, and counts all of them.
  task automatic report_mismatch(string what, int got, int want);
    error_count++;
    if (error_count <= PRINT_CAP) begin
      $display("cycle %0d: %s: got %0h, wanted %0h", cycle_count, what, got, want);
    end
  endtask

  // Applies one request word to the software store and returns the response word it causes.
  function automatic rsp_word_t queue_step(req_word_t w);
    rsp_word_t r;
    key_t      k;
    int        pos;
    r = '0;
    k = w.priority_req[KEY_BITS-1:0];
    pos = 0;
    case (action_t'(w.action))
      ACT_ENQUEUE: begin
        if (model_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          // The new key goes behind every stored key that is not below it.
          while (pos < model_count && model_keys[pos] >= k) pos++;
          for (int i = model_count; i > pos; i--) model_keys[i] = model_keys[i-1];
          model_keys[pos] = k;
          model_count++;
        end
      end
      ACT_DEQUEUE: begin
        if (model_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.removed_priority = model_keys[0];
          for (int i = 0; i + 1 < model_count; i++) model_keys[i] = model_keys[i+1];
          model_count--;
        end
      end
      ACT_CLEAR: begin
        model_count = 0;
      end
      default: begin
      end
    endcase
    r.front_priority = (model_count > 0) ? model_keys[0] : '0;
    r.occupancy = model_count[OCC_BITS-1:0];
    return r;
  endfunction

  function automatic void add_word(action_t a, logic [PRIO_BITS-1:0] key);
    stim_row_t row;
    row = '0;
    row.req.action = a;
    row.req.priority_req = key;
    stim.push_back(row);
  endfunction

  function automatic void add_checked(action_t a, logic [PRIO_BITS-1:0] key,
                                      logic [PRIO_BITS-1:0] removed,
                                      logic [PRIO_BITS-1:0] front,
                                      logic [OCC_BITS-1:0] occ, status_t st);
    stim_row_t row;
    row.req.action = a;
    row.req.priority_req = key;
    row.typed = 1'b1;
    row.rsp.removed_priority = removed;
    row.rsp.front_priority = front;
    row.rsp.occupancy = occ;
    row.rsp.status = st;
    stim.push_back(row);
  endfunction

  // Keys: uniform values, repeats from a small pool, extremes and small values.
  function automatic logic [PRIO_BITS-1:0] pick_key();
    int mode;
    mode = $urandom_range(0, 99);
    if (mode < 45) return PRIO_BITS'($urandom_range(0, 16'hFFFF));
    if (mode < 65) return 16'h4000 + 16'($urandom_range(0, 3));
    if (mode < 80) return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
    return PRIO_BITS'($urandom_range(0, 15));
  endfunction

  // Directed table, then random segments that lean towards filling, draining or neither.
  function automatic void build_stimulus();
    int left;
    int seg_left;
    int enq_pct;
    int roll;
    add_checked(ACT_DEQUEUE, 16'h0000, 16'h0000, 16'h0000, 5'd0, ST_EMPTY);
    add_checked(ACT_ENQUEUE, 16'h0000, 16'h0000, 16'h0000, 5'd1, ST_OK);
    add_checked(ACT_ENQUEUE, 16'hFFFF, 16'h0000, 16'hFFFF, 5'd2, ST_OK);
    add_checked(ACT_ENQUEUE, 16'hFFFF, 16'h0000, 16'hFFFF, 5'd3, ST_OK);
    add_word(ACT_ENQUEUE, 16'h5555);
    add_word(ACT_ENQUEUE, 16'hAAAA);
    add_checked(ACT_DEQUEUE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd4, ST_OK);
    add_word(ACT_NOP, 16'hFFFF);
    add_checked(ACT_CLEAR, 16'h1234, 16'h0000, 16'h0000, 5'd0, ST_OK);
    add_checked(ACT_DEQUEUE, 16'hFFFF, 16'h0000, 16'h0000, 5'd0, ST_EMPTY);
    // Walk a single set bit down through every key bit until the store is full.
    for (int i = 0; i < CAPACITY; i++) add_word(ACT_ENQUEUE, 16'h8000 >> i);
    add_checked(ACT_ENQUEUE, 16'hFFFF, 16'h0000, 16'h8000, 5'd16, ST_FULL);
    add_checked(ACT_DEQUEUE, 16'h0000, 16'h8000, 16'h4000, 5'd15, ST_OK);

    left = RANDOM_WORDS;
    seg_left = 0;
    enq_pct = 45;
    while (left > 0) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(10, 40);
        case ($urandom_range(0, 2))
          0: enq_pct = 70;
          1: enq_pct = 20;
          default: enq_pct = 45;
        endcase
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) add_word(ACT_CLEAR, pick_key());
      else if (roll < 6) add_word(ACT_NOP, pick_key());
      else if (roll < 6 + enq_pct) add_word(ACT_ENQUEUE, pick_key());
      else add_word(ACT_DEQUEUE, pick_key());
      seg_left--;
      left--;
    end
  endfunction

  // Response checker: every strobed word must match the oldest outstanding expectation.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("response word with nothing outstanding",
                        int'(rsp.front_priority), 0);
      end else begin
        due = pending_rsp.pop_front();
        checked_count++;
        if (rsp.removed_priority !== due.removed_priority)
          report_mismatch("removed_priority", int'(rsp.removed_priority),
                          int'(due.removed_priority));
        if (rsp.front_priority !== due.front_priority)
          report_mismatch("front_priority", int'(rsp.front_priority),
                          int'(due.front_priority));
        if (rsp.occupancy !== due.occupancy)
          report_mismatch("occupancy", int'(rsp.occupancy), int'(due.occupancy));
        if (rsp.status !== due.status)
          report_mismatch("status", int'(rsp.status), int'(due.status));
      end
    end
  end

  // Request driver: bursts of random length with random gaps between them.
  initial begin : main
    int        sent;
    int        burst_left;
    int        gap_left;
    logic      accepted;
    rsp_word_t predicted;
    sent = 0;
    burst_left = $urandom_range(1, 30);
    gap_left = 0;
    for (int i = 0; i < CAPACITY; i++) model_keys[i] = '0;
    build_stimulus();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (sent < stim.size()) begin
      @(posedge clk);
      accepted = start && !busy;
      if (accepted) begin
        // The model moves on for every word; typed rows supply their own response.
        predicted = queue_step(stim[sent].req);
        pending_rsp.push_back(stim[sent].typed ? stim[sent].rsp : predicted);
        if (predicted.status == ST_FULL) full_hits++;
        if (predicted.status == ST_EMPTY) empty_hits++;
        if (model_count > peak_count) peak_count = model_count;
        sent++;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 99) < 35) ? 0 : $urandom_range(1, 12);
        end
      end
      if (accepted || !start) begin
        if (gap_left > 0 || sent == stim.size()) begin
          start <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          start <= 1'b1;
          req <= stim[sent].req;
        end
      end
    end

    // Drain the outstanding responses, then keep watching for stray strobes before the summary.
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    $display("covered %0d request words, %0d responses checked", sent, checked_count);
    $display("store full %0d times, empty %0d times, peak occupancy %0d",
             full_hits, empty_hits, peak_count);
    if (error_count == 0) begin
      $display("sorted_insert_priority_queue_unit_tb: done, clean");
    end else begin
      $display("%0d mismatches", error_count);
      $display("sorted_insert_priority_queue_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
